FILE: rtl/mme_pkg.sv
// Shared types and constants of the matrix multiply engine.
package mme_pkg;

  localparam int DimW   = 4;
  localparam int IdxW   = 3;
  localparam int ElemW  = 32;
  localparam int CfgIdxW = 2;
  // Q16.16 fraction bits
  localparam int FracBits = 16;

  typedef enum logic [1:0] {
    OpWriteA  = 2'd0,
    OpWriteB  = 2'd1,
    OpCompute = 2'd2
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRowsA  = 2'd0,
    CfgInner  = 2'd1,
    CfgColsB  = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StMac  = 4'b0010,
    StWait = 4'b0100,
    StDone = 4'b1000
  } state_e;

  typedef struct packed {
    logic [1:0]              op;
    logic [IdxW-1:0]         row_index;
    logic [IdxW-1:0]         col_index;
    logic signed [ElemW-1:0] element;
  } in_beat_t;

  typedef struct packed {
    logic [IdxW-1:0]         out_row;
    logic [IdxW-1:0]         out_col;
    logic signed [ElemW-1:0] product_value;
    logic                    saturated;
    logic                    last;
  } out_beat_t;

endpackage

FILE: rtl/mme_stream_if.sv
// Valid/ready stream channel carrying one beat of type T.
interface mme_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/matrix_multiply_engine.sv
// A compute beat is accepted, then the engine emits rows_a*cols_b beats, each passing through issue
// reads, registered read, multiply and finish (finish alone when inner_size is 0); each beat can be
// held by an output stall.
// Throughput is set by the one shared 32x32 multiplier and the single read port of each
// store. Input is accepted only while idle.
// Reset: async active-low; dimension registers return to 8, stores are not cleared.
module matrix_multiply_engine #(
  parameter int MAX_DIM = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mme_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mme_pkg::DimW-1:0]     cfg_data_i,
  mme_stream_if.sink                   in_i,
  mme_stream_if.source                 out_o
);

  localparam int Depth = MAX_DIM * MAX_DIM;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int ProdW = 2 * mme_pkg::ElemW;
  localparam int AccW  = ProdW + $clog2(MAX_DIM) + 1;
  localparam logic [mme_pkg::DimW-1:0] MaxDim = mme_pkg::DimW'(MAX_DIM);

  function automatic logic [mme_pkg::DimW-1:0] clamp_dim(input logic [mme_pkg::DimW-1:0] d);
    return (d > MaxDim) ? MaxDim : d;
  endfunction

  // configuration
  logic [mme_pkg::DimW-1:0] rows_q, inner_q, cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= mme_pkg::DimW'(8);
      inner_q <= mme_pkg::DimW'(8);
      cols_q  <= mme_pkg::DimW'(8);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mme_pkg::CfgRowsA: rows_q  <= cfg_data_i;
        mme_pkg::CfgInner: inner_q <= cfg_data_i;
        mme_pkg::CfgColsB: cols_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [mme_pkg::DimW-1:0] nr, nn, nc;
  assign nr = clamp_dim(rows_q);
  assign nn = clamp_dim(inner_q);
  assign nc = clamp_dim(cols_q);

  // sequencer state
  mme_pkg::state_e          state_q, state_d;
  logic [mme_pkg::DimW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic                     rd_v_q, rd_l_q, mul_v_q, mul_l_q;
  logic                     issue, issue_last, acc_clr;
  logic                     out_v_q, out_v_d, load, last_elem;
  mme_pkg::out_beat_t       out_q, out_res;

  logic in_acc;
  assign in_i.ready = (state_q == mme_pkg::StIdle);
  assign in_acc     = in_i.valid && in_i.ready;

  // store writes
  logic wr_ok, we_a, we_b;
  logic [AddrW-1:0] wr_addr, rd_addr_a, rd_addr_b;

  assign wr_ok   = ({1'b0, in_i.data.row_index} < MaxDim) &&
                   ({1'b0, in_i.data.col_index} < MaxDim);
  assign we_a    = in_acc && wr_ok && (in_i.data.op == mme_pkg::OpWriteA);
  assign we_b    = in_acc && wr_ok && (in_i.data.op == mme_pkg::OpWriteB);
  assign wr_addr = AddrW'(int'(in_i.data.row_index) * MAX_DIM + int'(in_i.data.col_index));
  assign rd_addr_a = AddrW'(int'(i_q) * MAX_DIM + int'(k_q));
  assign rd_addr_b = AddrW'(int'(k_q) * MAX_DIM + int'(j_q));

  logic [mme_pkg::ElemW-1:0] mem_a [Depth];
  logic [mme_pkg::ElemW-1:0] mem_b [Depth];
  logic [mme_pkg::ElemW-1:0] a_rd_q, b_rd_q;

  always_ff @(posedge clk_i) begin
    if (we_a) begin
      mem_a[wr_addr] <= in_i.data.element;
    end
    a_rd_q <= mem_a[rd_addr_a];
  end

  always_ff @(posedge clk_i) begin
    if (we_b) begin
      mem_b[wr_addr] <= in_i.data.element;
    end
    b_rd_q <= mem_b[rd_addr_b];
  end

  // shared multiplier and accumulator
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q;

  always_ff @(posedge clk_i) begin
    prod_q <= $signed(a_rd_q) * $signed(b_rd_q);
    if (acc_clr) begin
      acc_q <= '0;
    end else if (mul_v_q) begin
      acc_q <= acc_q + AccW'(prod_q);
    end
  end

  // finish: truncate toward minus infinity, then saturate
  logic signed [AccW-1:0] acc_sh;
  logic                   neg, fits;
  assign acc_sh = acc_q >>> mme_pkg::FracBits;
  assign neg    = acc_q[AccW-1];
  assign fits   = neg ? (&acc_sh[AccW-1:mme_pkg::ElemW-1])
                      : ~(|acc_sh[AccW-1:mme_pkg::ElemW-1]);

  assign last_elem = (i_q == nr - 1'b1) && (j_q == nc - 1'b1);

  always_comb begin
    out_res.out_row       = i_q[mme_pkg::IdxW-1:0];
    out_res.out_col       = j_q[mme_pkg::IdxW-1:0];
    out_res.saturated     = !fits;
    out_res.last          = last_elem;
    if (fits) begin
      out_res.product_value = acc_sh[mme_pkg::ElemW-1:0];
    end else if (neg) begin
      out_res.product_value = {1'b1, {(mme_pkg::ElemW-1){1'b0}}};
    end else begin
      out_res.product_value = {1'b0, {(mme_pkg::ElemW-1){1'b1}}};
    end
  end

  assign load = (state_q == mme_pkg::StDone) && (!out_v_q || out_o.ready);

  always_comb begin
    state_d    = state_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    issue      = 1'b0;
    issue_last = 1'b0;
    acc_clr    = 1'b0;
    unique case (state_q)
      mme_pkg::StIdle: begin
        if (in_acc && (in_i.data.op == mme_pkg::OpCompute) &&
            (nr != '0) && (nc != '0)) begin
          state_d = mme_pkg::StMac;
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
          acc_clr = 1'b1;
        end
      end
      mme_pkg::StMac: begin
        if (nn == '0) begin
          state_d = mme_pkg::StDone;
        end else begin
          issue = 1'b1;
          k_d   = k_q + 1'b1;
          if (k_q == nn - 1'b1) begin
            issue_last = 1'b1;
            state_d    = mme_pkg::StWait;
          end
        end
      end
      mme_pkg::StWait: begin
        if (mul_v_q && mul_l_q) begin
          state_d = mme_pkg::StDone;
        end
      end
      mme_pkg::StDone: begin
        if (load) begin
          k_d     = '0;
          acc_clr = 1'b1;
          if (last_elem) begin
            state_d = mme_pkg::StIdle;
          end else begin
            state_d = mme_pkg::StMac;
            if (j_q == nc - 1'b1) begin
              j_d = '0;
              i_d = i_q + 1'b1;
            end else begin
              j_d = j_q + 1'b1;
            end
          end
        end
      end
      default: state_d = mme_pkg::StIdle;
    endcase
  end

  always_comb begin
    out_v_d = out_v_q;
    if (load) begin
      out_v_d = 1'b1;
    end else if (out_o.ready) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mme_pkg::StIdle;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      rd_v_q  <= 1'b0;
      rd_l_q  <= 1'b0;
      mul_v_q <= 1'b0;
      mul_l_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      rd_v_q  <= issue;
      rd_l_q  <= issue_last;
      mul_v_q <= rd_v_q;
      mul_l_q <= rd_l_q;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_res;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

  // no multiply-accumulate may be in flight while new beats are taken
  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> (!rd_v_q && !mul_v_q))
    else $error("pipeline busy while accepting input");

  // inner counter stays within the dot-product length while issuing
  a_k_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mme_pkg::StMac) |-> (k_q < nn || nn == '0))
    else $error("inner index overran inner_size");

  // final element of a run returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && last_elem) |=> (state_q == mme_pkg::StIdle && out_v_q && out_q.last))
    else $error("run did not end after last element");

endmodule
